/* hw/rtl/hsv_to_rgb_converter_top_macros.svh */
// Assertion helpers for the HSV to RGB converter.
// Both forms report through $error and are held off while reset is asserted.
`ifndef HSV_TO_RGB_CONVERTER_TOP_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// The condition holds at every clock edge outside reset.
`define HSV2RGB_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// When the antecedent holds, the consequent must hold in the next cycle.
`define HSV2RGB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HSV2RGB_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define HSV2RGB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* hw/rtl/hsv2rgb_pkg.sv */
package hsv2rgb_pkg;

    // Field widths of the pixel requests.
    localparam int HUE_W  = 15;
    localparam int COMP_W = 9;

    // Bounded product of chroma and the in-sector hue term after the sub-degree
    // shift: at most 511 * 60, so it fits in 15 bits.
    localparam int XNUM_W = 15;

    // Division by 60 as a multiply by a reciprocal. ceil(2^21 / 60) = 34953;
    // the rounding error times the largest numerator stays below 2^21, so the
    // truncated quotient is exact over the whole 15-bit range.
    localparam int                 RECIP_SHIFT = 21;
    localparam int                 RECIP_W     = 16;
    localparam logic [RECIP_W-1:0] RECIP_60    = 16'd34953;

    // Hue sector, 60 degrees each.
    typedef enum logic [2:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } t_sector;

    // Input pixel request.
    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [COMP_W-1:0] saturation;
        logic [COMP_W-1:0] brightness;
        logic [COMP_W-1:0] opacity;
    } t_hsv_req;

    // Output pixel request.
    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
        logic [COMP_W-1:0] alpha_out;
        logic              range_error;
    } t_rgb_req;

    // In odd sectors the secondary component falls as hue rises.
    function automatic logic sector_falls(input t_sector sec);
        logic odd;
        odd = (sec == SEC_1) || (sec == SEC_3) || (sec == SEC_5);
        return odd;
    endfunction

endpackage

/* hw/rtl/hsv_to_rgb_converter_top.sv */
// Channel   Dir  Handshake                 Payload
// ------------------------------------------------------------------
// input     in   i_in_valid / o_in_ready   i_in_req   (t_hsv_req)
// output    out  o_out_valid / i_out_ready o_out_req  (t_rgb_req)
//
// Five register stages: clamp, chroma multiply and sector decode, chroma times
// hue term, reciprocal divide by 60, channel mapping into the output register.
// One request is taken per clock while no stall holds the pipeline; the result
// is presented from the output register once it has passed through every stage.
// Each stage holds its request while the next one is full and stalled, so a
// bubble anywhere lets the input side keep accepting during an output stall.
// Synchronous active-low reset clears only the stage valid bits.
`include "hsv_to_rgb_converter_top_macros.svh"

module hsv_to_rgb_converter_top
    import hsv2rgb_pkg::*;
#(
    parameter int FRAC_BITS       = 8,
    parameter int HUE_SUBDEG_BITS = 6
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_hsv_req i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_rgb_req o_out_req
);

    // Widths for the component clamp limit, which is 1.0 = 2^FRAC_BITS.
    localparam int                CMP_W  = (FRAC_BITS + 1 > COMP_W) ? FRAC_BITS + 1 : COMP_W;
    localparam logic [CMP_W-1:0]  FX_ONE = CMP_W'(1) << FRAC_BITS;

    // Widths for hue: a full turn is 360 << HUE_SUBDEG_BITS, a sector 60 << it.
    localparam int                HCMP_W   = (9 + HUE_SUBDEG_BITS > HUE_W) ?
                                             9 + HUE_SUBDEG_BITS : HUE_W;
    localparam int                SEC_W    = 6 + HUE_SUBDEG_BITS;
    localparam logic [HCMP_W-1:0] HUE_FULL = HCMP_W'(360) << HUE_SUBDEG_BITS;
    localparam logic [HCMP_W-1:0] HUE_S1   = HCMP_W'(60)  << HUE_SUBDEG_BITS;
    localparam logic [HCMP_W-1:0] HUE_S2   = HCMP_W'(120) << HUE_SUBDEG_BITS;
    localparam logic [HCMP_W-1:0] HUE_S3   = HCMP_W'(180) << HUE_SUBDEG_BITS;
    localparam logic [HCMP_W-1:0] HUE_S4   = HCMP_W'(240) << HUE_SUBDEG_BITS;
    localparam logic [HCMP_W-1:0] HUE_S5   = HCMP_W'(300) << HUE_SUBDEG_BITS;
    localparam logic [SEC_W-1:0]  SEC_LEN  = SEC_W'(60) << HUE_SUBDEG_BITS;

    localparam int PROD_W  = 2 * COMP_W;
    localparam int XPROD_W = COMP_W + SEC_W;
    localparam int RPROD_W = XNUM_W + RECIP_W;

    // Stage valid bits and per-stage ready.
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;

    // Stage 1: clamped inputs.
    logic [HUE_W-1:0]  r1_h, n1_h;
    logic [COMP_W-1:0] r1_s, n1_s, r1_v, n1_v, r1_a, n1_a;
    logic              r1_err, n1_err;

    // Stage 2: chroma, sector and hue term.
    logic [COMP_W-1:0] r2_c, n2_c, r2_v, r2_a;
    logic [SEC_W-1:0]  r2_term, n2_term;
    t_sector           r2_sec, n2_sec;
    logic              r2_err;

    // Stage 3: chroma times hue term, sub-degree bits dropped.
    logic [XNUM_W-1:0] r3_n, n3_n;
    logic [COMP_W-1:0] r3_c, r3_v, r3_a;
    t_sector           r3_sec;
    logic              r3_err;

    // Stage 4: secondary component X.
    logic [COMP_W-1:0] r4_x, n4_x, r4_c, r4_v, r4_a;
    t_sector           r4_sec;
    logic              r4_err;

    // Stage 5: output register.
    t_rgb_req          r5_out, n5_out;

    // A stage can load when it is empty or its content moves on this clock.
    assign w_rdy5 = !r_v5 || i_out_ready;
    assign w_rdy4 = !r_v4 || w_rdy5;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;

    assign o_in_ready  = w_rdy1;
    assign o_out_valid = r_v5;
    assign o_out_req   = r5_out;

    // Valid bits advance with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_in_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
            if (w_rdy5) r_v5 <= r_v4;
        end
    end

    // Clamp components to 1.0 and hue to a full turn, flagging any clamp.
    always_comb begin
        logic err_s, err_v, err_a, err_h;
        err_s  = CMP_W'(i_in_req.saturation) > FX_ONE;
        err_v  = CMP_W'(i_in_req.brightness) > FX_ONE;
        err_a  = CMP_W'(i_in_req.opacity) > FX_ONE;
        err_h  = HCMP_W'(i_in_req.hue) > HUE_FULL;
        n1_s   = err_s ? COMP_W'(FX_ONE) : i_in_req.saturation;
        n1_v   = err_v ? COMP_W'(FX_ONE) : i_in_req.brightness;
        n1_a   = err_a ? COMP_W'(FX_ONE) : i_in_req.opacity;
        n1_h   = err_h ? HUE_W'(HUE_FULL) : i_in_req.hue;
        n1_err = err_s || err_v || err_a || err_h;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r1_h   <= n1_h;
            r1_s   <= n1_s;
            r1_v   <= n1_v;
            r1_a   <= n1_a;
            r1_err <= n1_err;
        end
    end

    // Chroma, and the sector found from its five boundaries and the full turn.
    // A hue of exactly a full turn lands in sector zero with no remainder.
    always_comb begin
        logic [PROD_W-1:0] prod;
        logic [HCMP_W-1:0] h_ext;
        logic [HCMP_W-1:0] base;
        logic [SEC_W-1:0]  rem;
        prod  = PROD_W'(r1_v) * PROD_W'(r1_s);
        n2_c  = COMP_W'(prod >> FRAC_BITS);
        h_ext = HCMP_W'(r1_h);
        priority if (h_ext >= HUE_FULL) begin
            n2_sec = SEC_0;
            base   = HUE_FULL;
        end else if (h_ext >= HUE_S5) begin
            n2_sec = SEC_5;
            base   = HUE_S5;
        end else if (h_ext >= HUE_S4) begin
            n2_sec = SEC_4;
            base   = HUE_S4;
        end else if (h_ext >= HUE_S3) begin
            n2_sec = SEC_3;
            base   = HUE_S3;
        end else if (h_ext >= HUE_S2) begin
            n2_sec = SEC_2;
            base   = HUE_S2;
        end else if (h_ext >= HUE_S1) begin
            n2_sec = SEC_1;
            base   = HUE_S1;
        end else begin
            n2_sec = SEC_0;
            base   = '0;
        end
        rem     = SEC_W'(h_ext - base);
        n2_term = sector_falls(n2_sec) ? SEC_W'(SEC_LEN - rem) : rem;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r2_c    <= n2_c;
            r2_v    <= r1_v;
            r2_a    <= r1_a;
            r2_sec  <= n2_sec;
            r2_term <= n2_term;
            r2_err  <= r1_err;
        end
    end

    // Chroma times hue term; dropping the sub-degree bits leaves a divide by 60.
    always_comb begin
        logic [XPROD_W-1:0] xprod;
        xprod = XPROD_W'(r2_c) * XPROD_W'(r2_term);
        n3_n  = xprod[HUE_SUBDEG_BITS +: XNUM_W];
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r3_n   <= n3_n;
            r3_c   <= r2_c;
            r3_v   <= r2_v;
            r3_a   <= r2_a;
            r3_sec <= r2_sec;
            r3_err <= r2_err;
        end
    end

    // Divide by 60 through the reciprocal multiply.
    always_comb begin
        logic [RPROD_W-1:0] rprod;
        rprod = RPROD_W'(r3_n) * RPROD_W'(RECIP_60);
        n4_x  = rprod[RECIP_SHIFT +: COMP_W];
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r4_x   <= n4_x;
            r4_c   <= r3_c;
            r4_v   <= r3_v;
            r4_a   <= r3_a;
            r4_sec <= r3_sec;
            r4_err <= r3_err;
        end
    end

    // Place C and X by sector and lift every channel by value minus chroma.
    always_comb begin
        logic [COMP_W-1:0] m;
        logic [COMP_W-1:0] rp, gp, bp;
        m = r4_v - r4_c;
        unique case (r4_sec)
            SEC_0: begin rp = r4_c; gp = r4_x; bp = '0;   end
            SEC_1: begin rp = r4_x; gp = r4_c; bp = '0;   end
            SEC_2: begin rp = '0;   gp = r4_c; bp = r4_x; end
            SEC_3: begin rp = '0;   gp = r4_x; bp = r4_c; end
            SEC_4: begin rp = r4_x; gp = '0;   bp = r4_c; end
            SEC_5: begin rp = r4_c; gp = '0;   bp = r4_x; end
            default: begin rp = '0; gp = '0;   bp = '0;   end
        endcase
        n5_out.red         = rp + m;
        n5_out.green       = gp + m;
        n5_out.blue        = bp + m;
        n5_out.alpha_out   = r4_a;
        n5_out.range_error = r4_err;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy5) begin
            r5_out <= n5_out;
        end
    end

    // Checks on the pipeline.
    `HSV2RGB_ASSERT_ALWAYS(a_x_within_chroma, i_clk, i_rst_n, !r_v4 || (r4_x <= r4_c), "X exceeds chroma")
    `HSV2RGB_ASSERT_ALWAYS(a_chroma_within_value, i_clk, i_rst_n, !r_v2 || (r2_c <= r2_v), "chroma exceeds value")
    `HSV2RGB_ASSERT_NEXT(a_stage4_holds, i_clk, i_rst_n, r_v4 && !w_rdy5, r_v4 && $stable(r4_x) && $stable(r4_c), "stage 4 lost data in stall")
    `HSV2RGB_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, i_in_valid && o_in_ready, r_v1, "accepted request not captured")

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import hsv2rgb_pkg::*;

    localparam int FRAC_BITS       = 8;
    localparam int HUE_SUBDEG_BITS = 6;
    localparam int unsigned UNIT       = 1 << FRAC_BITS;
    localparam int unsigned HUE_SECTOR = 60 << HUE_SUBDEG_BITS;
    localparam int unsigned HUE_FULL   = 360 << HUE_SUBDEG_BITS;
    localparam int          DRAIN_CYCLES = 12;

    // Expected RGBA requests, oldest first, and the converter they come from.
    class pixel_scoreboard;
        t_rgb_req    pending_rgb[$];
        int unsigned errors;

        // Saturate a component at 1.0 and flag it.
        function int unsigned clamp_unit(int unsigned val, inout logic err);
            if (val > UNIT) begin
                err = 1'b1;
                return UNIT;
            end
            return val;
        endfunction

        function t_rgb_req hsv_to_rgb(t_hsv_req px);
            t_rgb_req    rgb;
            t_sector     sec;
            logic        err;
            int unsigned hue, sat, val, alpha;
            int unsigned chroma, second, base, rem, rp, gp, bp;
            err   = 1'b0;
            hue   = 32'(px.hue);
            sat   = clamp_unit(32'(px.saturation), err);
            val   = clamp_unit(32'(px.brightness), err);
            alpha = clamp_unit(32'(px.opacity), err);
            if (hue > HUE_FULL) begin
                hue = HUE_FULL;
                err = 1'b1;
            end

            // Chroma and sector; a full turn wraps back to the first sector.
            chroma = (val * sat) >> FRAC_BITS;
            rem    = hue % HUE_SECTOR;
            if (hue / HUE_SECTOR >= 6) begin
                sec = SEC_0;
            end else begin
                sec = t_sector'(hue / HUE_SECTOR);
            end

            // The secondary component rises in even sectors and falls in odd ones.
            case (sec)
                SEC_1, SEC_3, SEC_5: second = (chroma * (HUE_SECTOR - rem)) / HUE_SECTOR;
                default:             second = (chroma * rem) / HUE_SECTOR;
            endcase

            case (sec)
                SEC_0: begin rp = chroma; gp = second; bp = 0;      end
                SEC_1: begin rp = second; gp = chroma; bp = 0;      end
                SEC_2: begin rp = 0;      gp = chroma; bp = second; end
                SEC_3: begin rp = 0;      gp = second; bp = chroma; end
                SEC_4: begin rp = second; gp = 0;      bp = chroma; end
                default: begin rp = chroma; gp = 0;    bp = second; end
            endcase

            base            = val - chroma;
            rgb.red         = COMP_W'(rp + base);
            rgb.green       = COMP_W'(gp + base);
            rgb.blue        = COMP_W'(bp + base);
            rgb.alpha_out   = COMP_W'(alpha);
            rgb.range_error = err;
            return rgb;
        endfunction

        function void note_request(t_hsv_req px);
            pending_rgb.push_back(hsv_to_rgb(px));
        endfunction

        function void report(string field, logic [COMP_W-1:0] want, logic [COMP_W-1:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        endfunction

        function void check_result(t_rgb_req got);
            t_rgb_req want;
            if (pending_rgb.size() == 0) begin
                errors++;
                $display("%0t: unexpected output request %h", $time, got);
                return;
            end
            want = pending_rgb.pop_front();
            if (got.red !== want.red)                 report("red", want.red, got.red);
            if (got.green !== want.green)             report("green", want.green, got.green);
            if (got.blue !== want.blue)               report("blue", want.blue, got.blue);
            if (got.alpha_out !== want.alpha_out)     report("alpha_out", want.alpha_out,
                                                             got.alpha_out);
            if (got.range_error !== want.range_error) report("range_error", want.range_error,
                                                             got.range_error);
        endfunction

        function int pending();
            return pending_rgb.size();
        endfunction
    endclass

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    t_hsv_req i_in_req    = '0;
    logic     i_out_ready = 1'b0;
    logic     o_in_ready;
    logic     o_out_valid;
    t_rgb_req o_out_req;

    int unsigned send_idle_pct = 38;
    int unsigned recv_idle_pct = 57;

    pixel_scoreboard board = new();

    hsv_to_rgb_converter_top #(
        .FRAC_BITS      (FRAC_BITS),
        .HUE_SUBDEG_BITS(HUE_SUBDEG_BITS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_req   (i_in_req),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_req  (o_out_req)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Give up long after the slowest legal run would have finished.
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // The receiver stalls at random with the current idle rate.
    initial begin
        forever begin
            @(negedge i_clk);
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Both handshakes are observed at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                board.note_request(i_in_req);
            end
            if (o_out_valid && i_out_ready) begin
                board.check_result(o_out_req);
            end
        end
    end

    function automatic t_hsv_req hsv_pixel(int unsigned hue, int unsigned sat,
                                           int unsigned val, int unsigned alpha);
        t_hsv_req px;
        px.hue        = HUE_W'(hue);
        px.saturation = COMP_W'(sat);
        px.brightness = COMP_W'(val);
        px.opacity    = COMP_W'(alpha);
        return px;
    endfunction

    // Mostly legal pixels, some near sector edges with extreme components, some noise.
    function automatic t_hsv_req random_pixel();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 75) begin
            return hsv_pixel($urandom_range(0, HUE_FULL), $urandom_range(0, UNIT),
                             $urandom_range(0, UNIT), $urandom_range(0, UNIT));
        end else if (pick < 87) begin
            return hsv_pixel(HUE_SECTOR * $urandom_range(0, 6) + $urandom_range(0, 1),
                             $urandom_range(0, 1) * UNIT, $urandom_range(0, 1) * UNIT,
                             $urandom_range(UNIT - 1, UNIT + 1));
        end
        return hsv_pixel($urandom_range(0, 32767), $urandom_range(0, 511),
                         $urandom_range(0, 511), $urandom_range(0, 511));
    endfunction

    // Present one request after a random gap and hold it until it is taken.
    task automatic send_pixel(input t_hsv_req px);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= px;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                             input int count);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) send_pixel(random_pixel());
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: every sector, the wrap at a full turn, clamping and zero saturation.
        send_pixel(hsv_pixel(0, 0, 0, 0));
        send_pixel(hsv_pixel(0, UNIT, UNIT, UNIT));
        send_pixel(hsv_pixel(HUE_SECTOR - 1, UNIT, UNIT, UNIT));
        send_pixel(hsv_pixel(HUE_SECTOR, UNIT, UNIT, UNIT));
        send_pixel(hsv_pixel(2 * HUE_SECTOR, UNIT, UNIT, UNIT));
        send_pixel(hsv_pixel(3 * HUE_SECTOR, UNIT, 200, UNIT));
        send_pixel(hsv_pixel(4 * HUE_SECTOR, 180, UNIT, 100));
        send_pixel(hsv_pixel(5 * HUE_SECTOR, UNIT, UNIT, 0));
        send_pixel(hsv_pixel(HUE_FULL - 1, UNIT, UNIT, UNIT));
        send_pixel(hsv_pixel(HUE_FULL, UNIT, UNIT, UNIT));
        send_pixel(hsv_pixel(HUE_FULL + 1, UNIT, UNIT, UNIT));
        send_pixel(hsv_pixel(32767, 511, 511, 511));
        send_pixel(hsv_pixel(5000, 0, 200, 100));
        send_pixel(hsv_pixel(1000, UNIT + 1, UNIT, UNIT));
        send_pixel(hsv_pixel(1000, UNIT, UNIT + 1, UNIT));
        send_pixel(hsv_pixel(1000, UNIT, UNIT, UNIT + 1));
        send_pixel(hsv_pixel(12000, 511, 0, 0));
        send_pixel(hsv_pixel(9000, 128, 511, 511));
        send_pixel(hsv_pixel(1920, 128, 200, 64));
        send_pixel(hsv_pixel(17000, 255, 255, 255));
        send_pixel(hsv_pixel(21000, 1, 1, 1));
        send_pixel(hsv_pixel(3000, UNIT, 1, 0));

        // Random traffic under three idling patterns.
        run_phase(38, 57, 443);
        run_phase(57, 38, 443);
        run_phase(0, 0, 443);
        i_in_valid <= 1'b0;

        // Drain the pipeline, then watch for stray outputs.
        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.errors == 0 && board.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
